// File: hdl/refcounted_frame_pool_defines.svh
// Assertion macros used by the frame pool top level.
`ifndef REFCOUNTED_FRAME_POOL_DEFINES_SVH
`define REFCOUNTED_FRAME_POOL_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define FRP_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define FRP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/frp_pkg.sv
// Package with the constants, codes and interface types of the frame pool.
`default_nettype none

package frp_pkg;

  localparam int POOL_DEPTH   = 32;
  localparam int ID_W         = 5;
  localparam int LEN_W        = 6;
  localparam int REF_BITS_DEF = 6;

  localparam logic [LEN_W-1:0] TALLY_MAX = '1;

  localparam logic [2:0] ACT_INIT      = 3'd0;
  localparam logic [2:0] ACT_DEC_TAKE  = 3'd1;
  localparam logic [2:0] ACT_DEC_REL   = 3'd2;
  localparam logic [2:0] ACT_HANDOVER  = 3'd3;
  localparam logic [2:0] ACT_DISP_TAKE = 3'd4;
  localparam logic [2:0] ACT_DISP_REL  = 3'd5;
  localparam logic [2:0] ACT_REQUEUE   = 3'd6;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_EMPTY  = 3'd1;
  localparam logic [2:0] ST_BADID  = 3'd2;
  localparam logic [2:0] ST_NEG    = 3'd3;
  localparam logic [2:0] ST_QUEUED = 3'd4;

  typedef logic [1:0] tag_t;

  localparam tag_t TAG_NONE = 2'd0;
  localparam tag_t TAG_FREE = 2'd1;
  localparam tag_t TAG_SHOW = 2'd2;

  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_cmd_t;

  typedef struct packed {
    logic move_more;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: hdl/frp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module frp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: hdl/frp_ctrl.sv
// Controller state machine that sequences the frame pool actions.
`default_nettype none

module frp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  frp_pkg::dp_stat_t stat,
  output logic              busy,
  output frp_pkg::ctrl_cmd_t cmd
);
  import frp_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_FETCH = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = stat.move_more ? S_FETCH : S_IDLE;
      end
      S_FETCH: begin
        state_next = S_EXEC;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy     = (state != S_IDLE);
  assign cmd.load = (state == S_IDLE) && start;
  assign cmd.exec = (state == S_EXEC);

endmodule

`default_nettype wire

// File: hdl/frp_datapath.sv
// Datapath with the queues, per-frame state, tallies and result registers.
`default_nettype none

module frp_datapath #(
  parameter int REF_BITS = frp_pkg::REF_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  frp_pkg::ctrl_cmd_t         cmd,
  output frp_pkg::dp_stat_t          stat,
  input  logic                       cfg_write,
  input  logic [frp_pkg::LEN_W-1:0]  cfg_data,
  input  logic [2:0]                 action,
  input  logic [frp_pkg::ID_W-1:0]   frame_id,
  input  logic                       show,
  output logic                       done,
  output logic [2:0]                 status,
  output logic [frp_pkg::ID_W-1:0]   granted_id,
  output logic [frp_pkg::LEN_W-1:0]  free_count,
  output logic [frp_pkg::LEN_W-1:0]  display_count
);
  import frp_pkg::*;

  localparam logic [REF_BITS-1:0] REF_MAX = '1;
  localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(POOL_DEPTH);

  logic [LEN_W-1:0]    pool_frames;
  logic [2:0]          act_q;
  logic [ID_W-1:0]     id_q;
  logic                show_bit;

  logic [ID_W-1:0]     free_head;
  logic [LEN_W-1:0]    free_len;
  logic [ID_W-1:0]     show_head;
  logic [LEN_W-1:0]    show_len;
  logic [LEN_W-1:0]    free_tally;
  logic [LEN_W-1:0]    show_tally;
  logic [POOL_DEPTH-1:0] fvalid;
  logic [REF_BITS-1:0] ref_cnt [POOL_DEPTH];
  logic                shown   [POOL_DEPTH];
  tag_t                tag     [POOL_DEPTH];

  logic [ID_W-1:0]     free_rdata;
  logic [ID_W-1:0]     show_rdata;
  logic                free_we;
  logic                show_we;
  logic [ID_W-1:0]     free_tail;
  logic [ID_W-1:0]     show_tail;

  logic [LEN_W-1:0]    n_use;
  logic                id_ok;
  logic [ID_W-1:0]     free_pop_id;
  logic [ID_W-1:0]     sel;
  logic [REF_BITS-1:0] cur_cnt;
  logic [REF_BITS-1:0] cnt_inc;
  logic [REF_BITS-1:0] cnt_dec;
  logic                cur_shown;
  tag_t                cur_tag;
  logic                free_full;
  logic                show_full;
  logic                move_more;
  logic                frees;

  logic [2:0]          res_status;
  logic [ID_W-1:0]     res_granted;
  logic                free_push, free_pop, show_push, show_pop;
  logic                cnt_we, shown_we, tag_we;
  logic [REF_BITS-1:0] cnt_new;
  logic                shown_new;
  tag_t                tag_new;
  logic                ftally_up, ftally_dn, stally_up, stally_dn;
  logic                do_init, do_requeue_end;

  frp_ram #(
    .WIDTH (ID_W),
    .DEPTH (POOL_DEPTH)
  ) u_free_ram (
    .clk   (clk),
    .we    (free_we),
    .waddr (free_tail),
    .wdata (sel),
    .raddr (free_head),
    .rdata (free_rdata)
  );

  frp_ram #(
    .WIDTH (ID_W),
    .DEPTH (POOL_DEPTH)
  ) u_show_ram (
    .clk   (clk),
    .we    (show_we),
    .waddr (show_tail),
    .wdata (sel),
    .raddr (show_head),
    .rdata (show_rdata)
  );

  always_comb begin
    if (pool_frames == '0) begin
      n_use = LEN_W'(1);
    end else if (pool_frames > DEPTH_LEN) begin
      n_use = DEPTH_LEN;
    end else begin
      n_use = pool_frames;
    end
  end

  assign id_ok       = {1'b0, id_q} < n_use;
  assign free_pop_id = fvalid[free_head] ? free_rdata : free_head;
  assign free_tail   = free_head + free_len[ID_W-1:0];
  assign show_tail   = show_head + show_len[ID_W-1:0];
  assign free_full   = (free_len >= DEPTH_LEN);
  assign show_full   = (show_len >= DEPTH_LEN);
  assign move_more   = (act_q == ACT_REQUEUE) && (show_len != '0) && !free_full;

  always_comb begin
    if (act_q == ACT_DEC_TAKE) begin
      sel = free_pop_id;
    end else if ((act_q == ACT_DISP_TAKE) || (act_q == ACT_REQUEUE)) begin
      sel = show_rdata;
    end else begin
      sel = id_q;
    end
  end

  assign cur_cnt   = ref_cnt[sel];
  assign cur_shown = shown[sel];
  assign cur_tag   = tag[sel];
  assign cnt_inc   = (cur_cnt == REF_MAX) ? cur_cnt : cur_cnt + 1'b1;
  assign cnt_dec   = cur_cnt - 1'b1;

  always_comb begin
    res_status     = ST_OK;
    res_granted    = '0;
    free_push      = 1'b0;
    free_pop       = 1'b0;
    show_push      = 1'b0;
    show_pop       = 1'b0;
    cnt_we         = 1'b0;
    cnt_new        = cur_cnt;
    shown_we       = 1'b0;
    shown_new      = cur_shown;
    tag_we         = 1'b0;
    tag_new        = cur_tag;
    ftally_up      = 1'b0;
    ftally_dn      = 1'b0;
    stally_up      = 1'b0;
    stally_dn      = 1'b0;
    do_init        = 1'b0;
    do_requeue_end = 1'b0;
    frees          = 1'b0;
    unique case (act_q) inside
      ACT_INIT: begin
        do_init = 1'b1;
      end
      ACT_DEC_TAKE: begin
        if (free_len == '0) begin
          res_status = ST_EMPTY;
        end else begin
          free_pop    = 1'b1;
          res_granted = sel;
          tag_we      = 1'b1;
          tag_new     = TAG_NONE;
          cnt_we      = 1'b1;
          cnt_new     = cnt_inc;
          shown_we    = 1'b1;
          shown_new   = 1'b0;
          ftally_dn   = 1'b1;
        end
      end
      ACT_DEC_REL, ACT_DISP_REL: begin
        frees = (cur_cnt == REF_BITS'(1)) &&
                ((act_q == ACT_DISP_REL) || cur_shown);
        if (!id_ok) begin
          res_status = ST_BADID;
        end else if (cur_cnt == '0) begin
          res_status = ST_NEG;
        end else if (frees && ((cur_tag != TAG_NONE) || free_full)) begin
          res_status = ST_QUEUED;
        end else begin
          if (frees) begin
            free_push = 1'b1;
            tag_we    = 1'b1;
            tag_new   = TAG_FREE;
            ftally_up = 1'b1;
          end
          cnt_we  = 1'b1;
          cnt_new = cnt_dec;
          if (act_q == ACT_DISP_REL) begin
            shown_we  = 1'b1;
            shown_new = 1'b1;
          end
        end
      end
      ACT_HANDOVER: begin
        if (!id_ok) begin
          res_status = ST_BADID;
        end else if (show_bit) begin
          if ((cur_tag != TAG_NONE) || show_full) begin
            res_status = ST_QUEUED;
          end else begin
            show_push = 1'b1;
            tag_we    = 1'b1;
            tag_new   = TAG_SHOW;
            cnt_we    = 1'b1;
            cnt_new   = cnt_inc;
            stally_up = 1'b1;
          end
        end else if ((cur_cnt == '0) && ((cur_tag != TAG_NONE) || free_full)) begin
          res_status = ST_QUEUED;
        end else begin
          if (cur_cnt == '0) begin
            free_push = 1'b1;
            tag_we    = 1'b1;
            tag_new   = TAG_FREE;
            ftally_up = 1'b1;
          end
          shown_we  = 1'b1;
          shown_new = 1'b1;
        end
      end
      ACT_DISP_TAKE: begin
        if (show_len == '0) begin
          res_status = ST_EMPTY;
        end else begin
          show_pop    = 1'b1;
          res_granted = sel;
          tag_we      = 1'b1;
          tag_new     = TAG_NONE;
          stally_dn   = 1'b1;
        end
      end
      ACT_REQUEUE: begin
        if (move_more) begin
          show_pop  = 1'b1;
          free_push = 1'b1;
          tag_we    = 1'b1;
          tag_new   = TAG_FREE;
        end else begin
          do_requeue_end = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign free_we = cmd.exec && free_push;
  assign show_we = cmd.exec && show_push;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_frames <= DEPTH_LEN;
      free_head   <= '0;
      free_len    <= DEPTH_LEN;
      show_head   <= '0;
      show_len    <= '0;
      free_tally  <= DEPTH_LEN;
      show_tally  <= '0;
      fvalid      <= '0;
      done        <= 1'b0;
      for (int i = 0; i < POOL_DEPTH; i++) begin
        ref_cnt[i] <= '0;
        shown[i]   <= 1'b0;
        tag[i]     <= TAG_FREE;
      end
    end else begin
      done <= 1'b0;
      if (cfg_write) begin
        pool_frames <= cfg_data;
      end
      if (cmd.exec) begin
        done <= !move_more;
        if (do_init) begin
          free_head  <= '0;
          free_len   <= n_use;
          show_head  <= '0;
          show_len   <= '0;
          free_tally <= n_use;
          show_tally <= '0;
          fvalid     <= '0;
          for (int i = 0; i < POOL_DEPTH; i++) begin
            ref_cnt[i] <= '0;
            shown[i]   <= 1'b0;
            tag[i]     <= (LEN_W'(i) < n_use) ? TAG_FREE : TAG_NONE;
          end
        end else begin
          if (free_pop) begin
            free_head <= free_head + 1'b1;
            free_len  <= free_len - 1'b1;
          end
          if (free_push) begin
            free_len          <= free_len + 1'b1;
            fvalid[free_tail] <= 1'b1;
          end
          if (show_pop) begin
            show_head <= show_head + 1'b1;
            show_len  <= show_len - 1'b1;
          end
          if (show_push) begin
            show_len <= show_len + 1'b1;
          end
          if (do_requeue_end) begin
            free_tally <= n_use;
            show_tally <= '0;
          end
          if (ftally_up && (free_tally != TALLY_MAX)) begin
            free_tally <= free_tally + 1'b1;
          end
          if (ftally_dn && (free_tally != '0)) begin
            free_tally <= free_tally - 1'b1;
          end
          if (stally_up && (show_tally != TALLY_MAX)) begin
            show_tally <= show_tally + 1'b1;
          end
          if (stally_dn && (show_tally != '0)) begin
            show_tally <= show_tally - 1'b1;
          end
          if (cnt_we) begin
            ref_cnt[sel] <= cnt_new;
          end
          if (shown_we) begin
            shown[sel] <= shown_new;
          end
          if (tag_we) begin
            tag[sel] <= tag_new;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_q    <= action;
      id_q     <= frame_id;
      show_bit <= show;
    end
    if (cmd.exec && !move_more) begin
      status     <= res_status;
      granted_id <= res_granted;
    end
  end

  assign stat.move_more = move_more;
  assign free_count     = free_tally;
  assign display_count  = show_tally;

endmodule

`default_nettype wire

// File: hdl/refcounted_frame_pool.sv
// Frame pool: an action is accepted in the idle state, then run in the execute state.
// The result strobe follows in the next cycle, in which the next start is taken.
// A requeue alternates the execute and fetch states per frame, one display queue read
// and one free queue write per frame through the registered-read queue memories.
// Reset is synchronous: all frames free, no clearing pass.
// The receiver cannot stall; each result is a single-cycle transfer.
`default_nettype none
`include "refcounted_frame_pool_defines.svh"

module refcounted_frame_pool #(
  parameter int REF_BITS = frp_pkg::REF_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [frp_pkg::LEN_W-1:0] cfg_data,
  input  logic                      start,
  output logic                      busy,
  input  logic [2:0]                action,
  input  logic [frp_pkg::ID_W-1:0]  frame_id,
  input  logic                      show,
  output logic                      done,
  output logic [2:0]                status,
  output logic [frp_pkg::ID_W-1:0]  granted_id,
  output logic [frp_pkg::LEN_W-1:0] free_count,
  output logic [frp_pkg::LEN_W-1:0] display_count
);
  import frp_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  frp_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  frp_datapath #(
    .REF_BITS (REF_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .action        (action),
    .frame_id      (frame_id),
    .show          (show),
    .done          (done),
    .status        (status),
    .granted_id    (granted_id),
    .free_count    (free_count),
    .display_count (display_count)
  );

  `FRP_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy, "Accepted transfer did not raise busy.")
  `FRP_ASSERT_IMPLIES(a_done_idle, clk, rst, done, !busy, "Result strobe while still busy.")
  `FRP_ASSERT_NEXT(a_exec_done, clk, rst, cmd.exec && !stat.move_more, done, "Finished action gave no result.")
  `FRP_ASSERT_IMPLIES(a_empty_grant, clk, rst, done && (status == ST_EMPTY), granted_id == '0, "Empty take granted an id.")

endmodule

`default_nettype wire
